// ===== rtl/ctpa_pkg.sv =====
// ctpa_pkg: shared types and constants for the cube texel to panorama address pipeline.
// Request structs, register codes, CORDIC table and fixed-point widths.
// No dependencies.
`timescale 1ns / 1ps

package ctpa_pkg;

  // Request payloads
  typedef struct packed {
    logic [2:0]  cube_face;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [12:0] pano_col;
    logic [11:0] pano_row;
    logic [26:0] element_offset;
  } out_item_t;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_FACE_EDGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANO_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PANO_HEIGHT = 2'd2;

  localparam logic [12:0] FACE_EDGE_RST   = 13'd512;
  localparam logic [13:0] PANO_WIDTH_RST  = 14'd2048;
  localparam logic [12:0] PANO_HEIGHT_RST = 13'd1024;

  // Face codes
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;

  // Fixed-point widths: direction components, CORDIC datapath, angles
  localparam int COMP_W = 17;
  localparam int CD_W   = 20;
  localparam int ANG_W  = 18;

  localparam logic signed [COMP_W-1:0] COMP_ONE = 17'sd32768;
  localparam logic signed [ANG_W-1:0]  ANG_HALF = 18'sd32768;
  localparam logic [15:0]              INV_GAIN = 16'd39797;

  // Vectoring CORDIC arctangents, 65536 per turn
  localparam int CORDIC_STEPS = 15;
  localparam logic signed [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
  };

  // Zero acts as one, oversize acts as the maximum
  function automatic int unsigned eff_size(input int unsigned r, input int unsigned m);
    int unsigned res;
    res = r;
    if (r == 0) res = 1;
    else if (r > m) res = m;
    return res;
  endfunction

endpackage

// ===== rtl/cubemap_texel_to_panorama_address.sv =====
// cubemap_texel_to_panorama_address: top level, config registers and pipeline chain.
// Uses ctpa_pkg, ctpa_coord, ctpa_cordic and ctpa_scale.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (cube_face, pixel_col, pixel_row)
//   out      output     out_valid/ out_stall out_data  (pano_col, pano_row, element_offset)
//   cfg      input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One request per cycle while no result waits on out_stall; stages: 16 divider steps plus face table,
// two 16-stage CORDICs, gain multiply, six-stage scaler.
// Reset is synchronous and clears valid bits and config registers to defaults.
// A stalled result holds the whole pipeline; in_stall follows out_stall only
// while a result is waiting. cfg_ready is always high.
`timescale 1ns / 1ps

module cubemap_texel_to_panorama_address #(
  parameter int MAX_FACE_EDGE   = 4096,
  parameter int MAX_PANO_WIDTH  = 8192,
  parameter int MAX_PANO_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ctpa_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ctpa_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ctpa_pkg::*;

  localparam int EW = $clog2(MAX_FACE_EDGE + 1);
  localparam int WW = $clog2(MAX_PANO_WIDTH + 1);
  localparam int HW = $clog2(MAX_PANO_HEIGHT + 1);

  // Configuration registers
  logic [12:0] face_edge;
  logic [13:0] pano_width;
  logic [12:0] pano_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_edge   <= FACE_EDGE_RST;
      pano_width  <= PANO_WIDTH_RST;
      pano_height <= PANO_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FACE_EDGE:   face_edge   <= cfg_data[12:0];
        REG_PANO_WIDTH:  pano_width  <= cfg_data;
        REG_PANO_HEIGHT: pano_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Effective sizes
  logic [EW-1:0] e_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign e_eff = EW'(eff_size(32'(face_edge), MAX_FACE_EDGE));
  assign w_eff = WW'(eff_size(32'(pano_width), MAX_PANO_WIDTH));
  assign h_eff = HW'(eff_size(32'(pano_height), MAX_PANO_HEIGHT));

  // Global advance: hold everything only while a result waits
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Face coordinates and direction
  logic                     c_valid;
  logic signed [COMP_W-1:0] cx, cy, cz;

  ctpa_coord #(.EW(EW)) u_coord (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .edge_len (e_eff),
    .out_valid(c_valid),
    .out_x    (cx),
    .out_y    (cy),
    .out_z    (cz)
  );

  // Longitude: atan2(z, x), y rides along
  logic                     l_valid;
  logic signed [CD_W-1:0]   l_x;
  logic signed [ANG_W-1:0]  l_ang;
  logic [COMP_W-1:0]        l_side;

  ctpa_cordic #(.SIDE_W(COMP_W)) u_lon (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .in_x     (CD_W'(cx)),
    .in_y     (CD_W'(cz)),
    .in_side  (cy),
    .out_valid(l_valid),
    .out_x    (l_x),
    .out_angle(l_ang),
    .out_side (l_side)
  );

  // Horizontal length: remove CORDIC gain
  logic [CD_W+15:0]         gprod;
  logic                     g_valid;
  logic signed [CD_W-1:0]   g_len;
  logic signed [COMP_W-1:0] g_y;
  logic signed [ANG_W-1:0]  g_lon;

  assign gprod = $unsigned(l_x) * INV_GAIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_len <= gprod[CD_W+15:16];
      g_y   <= l_side;
      g_lon <= l_ang;
    end
  end

  // Latitude: atan2(y, length), longitude rides along
  logic                    m_valid;
  logic signed [ANG_W-1:0] m_lat;
  logic [ANG_W-1:0]        m_lon;

  ctpa_cordic #(.SIDE_W(ANG_W)) u_lat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g_valid),
    .in_x     (g_len),
    .in_y     (CD_W'(g_y)),
    .in_side  (g_lon),
    .out_valid(m_valid),
    .out_x    (),
    .out_angle(m_lat),
    .out_side (m_lon)
  );

  // Column, row, offset
  ctpa_scale #(.WW(WW), .HW(HW)) u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .lon      ($signed(m_lon)),
    .lat      (m_lat),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Input is held off only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A waiting result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");

  // A taken result frees the input side in the same cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("pipeline did not advance on a taken result");

endmodule

// ===== rtl/ctpa_coord.sv =====
// ctpa_coord: texel position to face coordinates and direction vector.
// Two pipelined restoring dividers (one quotient bit per stage) and the face table.
// Depends on ctpa_pkg.
`timescale 1ns / 1ps

module ctpa_coord #(
  parameter int EW = 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  ctpa_pkg::in_item_t                   in_data,
  input  logic [EW-1:0]                        edge_len,
  output logic                                 out_valid,
  output logic signed [ctpa_pkg::COMP_W-1:0]   out_x,
  output logic signed [ctpa_pkg::COMP_W-1:0]   out_y,
  output logic signed [ctpa_pkg::COMP_W-1:0]   out_z
);
  import ctpa_pkg::*;

  localparam int DIV_STEPS = 16;

  // one long-division step: returns {quotient bit, new remainder}
  function automatic logic [EW:0] div_step(input logic [EW-1:0] rem, input logic b,
                                           input logic [EW-1:0] d);
    logic [EW:0] sh;
    logic [EW:0] diff;
    sh   = {rem, b};
    diff = sh - {1'b0, d};
    return (sh >= {1'b0, d}) ? {1'b1, diff[EW-1:0]} : {1'b0, sh[EW-1:0]};
  endfunction

  logic          vld [DIV_STEPS];
  logic [EW-1:0] ru  [DIV_STEPS];
  logic [EW-1:0] rv  [DIV_STEPS];
  logic [15:0]   qu  [DIV_STEPS];
  logic [15:0]   qv  [DIV_STEPS];
  logic [2:0]    fc  [DIV_STEPS];
  logic          su  [DIV_STEPS];
  logic          sv  [DIV_STEPS];

  // Divider stages: remainder starts at the position, then bits 1,0,0,...
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic          v_s;
    logic [EW-1:0] ru_s, rv_s;
    logic [15:0]   qu_s, qv_s;
    logic [2:0]    f_s;
    logic          su_s, sv_s;
    logic [EW:0]   nu, nv;

    if (k == 0) begin : g_first
      assign v_s  = in_valid;
      assign ru_s = EW'(in_data.pixel_col);
      assign rv_s = EW'(in_data.pixel_row);
      assign qu_s = '0;
      assign qv_s = '0;
      assign f_s  = in_data.cube_face;
      // position at or past the edge saturates
      assign su_s = 32'(in_data.pixel_col) >= 32'(edge_len);
      assign sv_s = 32'(in_data.pixel_row) >= 32'(edge_len);
    end else begin : g_next
      assign v_s  = vld[k-1];
      assign ru_s = ru[k-1];
      assign rv_s = rv[k-1];
      assign qu_s = qu[k-1];
      assign qv_s = qv[k-1];
      assign f_s  = fc[k-1];
      assign su_s = su[k-1];
      assign sv_s = sv[k-1];
    end

    assign nu = div_step(ru_s, k == 0, edge_len);
    assign nv = div_step(rv_s, k == 0, edge_len);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ru[k] <= nu[EW-1:0];
        rv[k] <= nv[EW-1:0];
        qu[k] <= {qu_s[14:0], nu[EW]};
        qv[k] <= {qv_s[14:0], nv[EW]};
        fc[k] <= f_s;
        su[k] <= su_s;
        sv[k] <= sv_s;
      end
    end
  end

  // Q1.15 coordinates: quotient minus 32768, saturated
  logic signed [15:0] u16, v16;
  logic signed [COMP_W-1:0] u, v;
  logic signed [COMP_W-1:0] x_next, y_next, z_next;

  assign u16 = su[DIV_STEPS-1] ? 16'sd32767
             : {~qu[DIV_STEPS-1][15], qu[DIV_STEPS-1][14:0]};
  assign v16 = sv[DIV_STEPS-1] ? 16'sd32767
             : {~qv[DIV_STEPS-1][15], qv[DIV_STEPS-1][14:0]};
  assign u = COMP_W'(u16);
  assign v = COMP_W'(v16);

  // Face table; codes six and seven fall to -Z
  always_comb begin
    unique case (fc[DIV_STEPS-1])
      FACE_PX: begin x_next = COMP_ONE;  y_next = -v;        z_next = -u;        end
      FACE_NX: begin x_next = -COMP_ONE; y_next = -v;        z_next = u;         end
      FACE_PY: begin x_next = u;         y_next = COMP_ONE;  z_next = v;         end
      FACE_NY: begin x_next = u;         y_next = -COMP_ONE; z_next = -v;        end
      FACE_PZ: begin x_next = u;         y_next = -v;        z_next = COMP_ONE;  end
      default: begin x_next = -u;        y_next = -v;        z_next = -COMP_ONE; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
    end
  end

endmodule

// ===== rtl/ctpa_cordic.sv =====
// ctpa_cordic: pipelined vectoring CORDIC, one micro-rotation per stage.
// Gives atan2(y, x) in turn units and the gain-scaled magnitude; carries a side word.
// Depends on ctpa_pkg.
`timescale 1ns / 1ps

module ctpa_cordic #(
  parameter int SIDE_W = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ctpa_pkg::CD_W-1:0]   in_x,
  input  logic signed [ctpa_pkg::CD_W-1:0]   in_y,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_valid,
  output logic signed [ctpa_pkg::CD_W-1:0]   out_x,
  output logic signed [ctpa_pkg::ANG_W-1:0]  out_angle,
  output logic [SIDE_W-1:0]                  out_side
);
  import ctpa_pkg::*;

  // Pre-rotation stage: half turn for the left half plane, zero detect
  logic                    v0, z0;
  logic signed [CD_W-1:0]  x0, y0;
  logic signed [ANG_W-1:0] a0;
  logic [SIDE_W-1:0]       s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= (in_x == '0) && (in_y == '0);
      s0 <= in_side;
      if (in_x < 0) begin
        x0 <= -in_x;
        y0 <= -in_y;
        a0 <= (in_y >= 0) ? ANG_HALF : -ANG_HALF;
      end else begin
        x0 <= in_x;
        y0 <= in_y;
        a0 <= '0;
      end
    end
  end

  logic                    vld [CORDIC_STEPS];
  logic                    zf  [CORDIC_STEPS];
  logic signed [CD_W-1:0]  xs  [CORDIC_STEPS];
  logic signed [CD_W-1:0]  ys  [CORDIC_STEPS];
  logic signed [ANG_W-1:0] as  [CORDIC_STEPS];
  logic [SIDE_W-1:0]       sd  [CORDIC_STEPS];

  // Micro-rotations, drive y toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic                    v_s, z_s;
    logic signed [CD_W-1:0]  x_s, y_s, dx, dy;
    logic signed [ANG_W-1:0] a_s;
    logic [SIDE_W-1:0]       s_s;

    if (i == 0) begin : g_first
      assign v_s = v0;
      assign z_s = z0;
      assign x_s = x0;
      assign y_s = y0;
      assign a_s = a0;
      assign s_s = s0;
    end else begin : g_next
      assign v_s = vld[i-1];
      assign z_s = zf[i-1];
      assign x_s = xs[i-1];
      assign y_s = ys[i-1];
      assign a_s = as[i-1];
      assign s_s = sd[i-1];
    end

    assign dx = y_s >>> i;
    assign dy = x_s >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i] <= z_s;
        sd[i] <= s_s;
        if (!y_s[CD_W-1]) begin
          xs[i] <= x_s + dx;
          ys[i] <= y_s - dy;
          as[i] <= a_s + ATAN_TURN[i];
        end else begin
          xs[i] <= x_s - dx;
          ys[i] <= y_s + dy;
          as[i] <= a_s - ATAN_TURN[i];
        end
      end
    end
  end

  // zero vector reads as angle zero; its magnitude is already zero
  assign out_valid = vld[CORDIC_STEPS-1];
  assign out_x     = xs[CORDIC_STEPS-1];
  assign out_angle = zf[CORDIC_STEPS-1] ? '0 : as[CORDIC_STEPS-1];
  assign out_side  = sd[CORDIC_STEPS-1];

endmodule

// ===== rtl/ctpa_scale.sv =====
// ctpa_scale: longitude/latitude to panorama column, row and element offset.
// Six register stages: clamp, multiply, clamp, multiply, add, times three.
// Depends on ctpa_pkg.
`timescale 1ns / 1ps

module ctpa_scale #(
  parameter int WW = 14,
  parameter int HW = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ctpa_pkg::ANG_W-1:0]  lon,
  input  logic signed [ctpa_pkg::ANG_W-1:0]  lat,
  input  logic [WW-1:0]                      w_eff,
  input  logic [HW-1:0]                      h_eff,
  output logic                               out_valid,
  output ctpa_pkg::out_item_t                out_data
);
  import ctpa_pkg::*;

  logic v1, v2, v3, v4, v5;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      out_valid <= v5;
    end
  end

  // Stage 1: offset and clamp the angles
  logic signed [ANG_W:0] t_full, p_full;
  logic [16:0] t1;
  logic [15:0] p1;

  assign t_full = (ANG_W+1)'(lon) + 19'sd32768;
  assign p_full = (ANG_W+1)'(lat) + 19'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      if (t_full < 0)              t1 <= '0;
      else if (t_full > 19'sd65536) t1 <= 17'd65536;
      else                          t1 <= t_full[16:0];
      if (p_full < 0)              p1 <= '0;
      else if (p_full > 19'sd32768) p1 <= 16'd32768;
      else                          p1 <= p_full[15:0];
    end
  end

  // Stage 2: scale by size
  logic [16+WW:0] tw2;
  logic [15+HW:0] ph2;

  always_ff @(posedge clk) begin
    if (en) begin
      tw2 <= t1 * w_eff;
      ph2 <= p1 * h_eff;
    end
  end

  // Stage 3: drop fraction, clamp to size minus one
  logic [WW:0]   pcr;
  logic [HW:0]   prr;
  logic [WW-1:0] pc3;
  logic [HW-1:0] pr3;

  assign pcr = tw2[16+WW:16];
  assign prr = ph2[15+HW:15];

  always_ff @(posedge clk) begin
    if (en) begin
      pc3 <= (pcr >= {1'b0, w_eff}) ? w_eff - 1'b1 : pcr[WW-1:0];
      pr3 <= (prr >= {1'b0, h_eff}) ? h_eff - 1'b1 : prr[HW-1:0];
    end
  end

  // Stage 4: row times width
  logic [HW+WW-1:0] prw4;
  logic [WW-1:0]    pc4;
  logic [HW-1:0]    pr4;

  always_ff @(posedge clk) begin
    if (en) begin
      prw4 <= pr3 * w_eff;
      pc4  <= pc3;
      pr4  <= pr3;
    end
  end

  // Stage 5: add column
  logic [26:0]   sum5;
  logic [WW-1:0] pc5;
  logic [HW-1:0] pr5;

  always_ff @(posedge clk) begin
    if (en) begin
      sum5 <= 27'(prw4) + 27'(pc4);
      pc5  <= pc4;
      pr5  <= pr4;
    end
  end

  // Stage 6: three channels per pixel
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.element_offset <= {sum5[25:0], 1'b0} + sum5;
      out_data.pano_col       <= 13'(pc5);
      out_data.pano_row       <= 12'(pr5);
    end
  end

endmodule

// ===== dv/cubemap_texel_to_panorama_address_tb.sv =====
// Self-checking testbench for cubemap_texel_to_panorama_address.
// Predicts panorama column, row and offset per texel request; depends on ctpa_pkg and the RTL.
`timescale 1ns / 1ps

module cubemap_texel_to_panorama_address_tb;
  import ctpa_pkg::*;

  // Panorama address predictor and store of expected addresses
  class pano_scoreboard;
    int unsigned edge_reg  = 32'(FACE_EDGE_RST);
    int unsigned width_reg = 32'(PANO_WIDTH_RST);
    int unsigned height_reg = 32'(PANO_HEIGHT_RST);
    out_item_t   pending_addr[$];
    int          mismatches = 0;
    int          checked = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FACE_EDGE:   edge_reg   = 32'(val & 14'h1FFF);
        REG_PANO_WIDTH:  width_reg  = 32'(val);
        REG_PANO_HEIGHT: height_reg = 32'(val & 14'h1FFF);
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned r, int unsigned m);
      if (r == 0) return 1;
      return (r > m) ? m : r;
    endfunction

    function longint texel_to_uv(int unsigned pos, int unsigned e);
      longint q;
      q = ((longint'(2 * pos + 1)) << 15) / e - 32768;
      return (q > 32767) ? 32767 : q;
    endfunction

    // Vectoring CORDIC: angle in 1/65536 turns, gain-corrected length
    function void vector_angle(longint x, longint y, output longint ang, output longint len);
      ang = 0;
      len = 0;
      if (x == 0 && y == 0) return;
      if (x < 0) begin
        ang = (y >= 0) ? 32768 : -32768;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        longint dx, dy;
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; ang += ATAN_TURN[i];
        end else begin
          x -= dx; y += dy; ang -= ATAN_TURN[i];
        end
      end
      len = (x * 39797) >> 16;
    endfunction

    function void note_request(in_item_t req);
      int unsigned e, w, h;
      longint u, v, x, y, z, lon, lat, horiz, unused, t, p, pc, pr;
      out_item_t exp_addr;
      e = clamp_size(edge_reg, 4096);
      w = clamp_size(width_reg, 8192);
      h = clamp_size(height_reg, 4096);
      u = texel_to_uv(req.pixel_col, e);
      v = texel_to_uv(req.pixel_row, e);
      case (req.cube_face)
        FACE_PX: begin x = 32768;  y = -v;     z = -u;    end
        FACE_NX: begin x = -32768; y = -v;     z = u;     end
        FACE_PY: begin x = u;      y = 32768;  z = v;     end
        FACE_NY: begin x = u;      y = -32768; z = -v;    end
        FACE_PZ: begin x = u;      y = -v;     z = 32768; end
        default: begin x = -u;     y = -v;     z = -32768; end  // -Z and unused codes
      endcase
      vector_angle(x, z, lon, horiz);
      vector_angle(horiz, y, lat, unused);
      t = lon + 32768;
      if (t < 0) t = 0;
      if (t > 65536) t = 65536;
      pc = (t * w) >> 16;
      if (pc > w - 1) pc = w - 1;
      p = lat + 16384;
      if (p < 0) p = 0;
      if (p > 32768) p = 32768;
      pr = (p * h) >> 15;
      if (pr > h - 1) pr = h - 1;
      exp_addr.pano_col       = 13'(pc);
      exp_addr.pano_row       = 12'(pr);
      exp_addr.element_offset = 27'((pr * w + pc) * 3);
      pending_addr.push_back(exp_addr);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_addr;
      checked++;
      if (pending_addr.size() == 0) begin
        $error("unexpected result %p", got);
        mismatches++;
        return;
      end
      exp_addr = pending_addr.pop_front();
      if (got.pano_col !== exp_addr.pano_col) begin
        $error("pano_col expected %0d got %0d", exp_addr.pano_col, got.pano_col);
        mismatches++;
      end
      if (got.pano_row !== exp_addr.pano_row) begin
        $error("pano_row expected %0d got %0d", exp_addr.pano_row, got.pano_row);
        mismatches++;
      end
      if (got.element_offset !== exp_addr.element_offset) begin
        $error("element_offset expected %0d got %0d", exp_addr.element_offset,
               got.element_offset);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pano_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 0;
  int  hold_left = 0;
  int  reqs_sent = 0;
  int  cfg_sets = 0;

  cubemap_texel_to_panorama_address u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result monitor and random stall; one long hold-off when requested
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_request && hold_left == 0) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    reqs_sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Wait for every expected address, then the pipeline latency
  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending_addr.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic random_texel(output in_item_t req);
    int unsigned e;
    e = sb.clamp_size(sb.edge_reg, 4096);
    req.cube_face = 3'($urandom_range(7));
    if ($urandom_range(99) < 85) begin
      req.pixel_col = 12'($urandom_range(e - 1));
      req.pixel_row = 12'($urandom_range(e - 1));
    end else begin
      req.pixel_col = 12'($urandom_range(4095));
      req.pixel_row = 12'($urandom_range(4095));
    end
  endtask

  initial begin
    logic [13:0] edge_set[8]   = '{512, 1, 0, 4096, 8191, 3, 0, 0};
    logic [13:0] width_set[8]  = '{2048, 1, 0, 8192, 16383, 5, 0, 0};
    logic [13:0] height_set[8] = '{1024, 1, 0, 4096, 8191, 7, 0, 0};
    logic [11:0] corner[3]     = '{0, 511, 4095};
    in_item_t    req;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every face code at texel corners and beyond the edge
    for (int f = 0; f < 8; f++)
      for (int k = 0; k < 3; k++) begin
        req.cube_face = 3'(f);
        req.pixel_col = corner[k];
        req.pixel_row = corner[2 - k];
        send_request(req);
      end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph >= 6) begin
        edge_set[ph]   = 14'($urandom_range(1, 64));
        width_set[ph]  = 14'($urandom_range(16383));
        height_set[ph] = 14'($urandom_range(8191));
      end
      if (ph > 0) begin
        write_cfg(REG_FACE_EDGE, edge_set[ph]);
        write_cfg(REG_PANO_WIDTH, width_set[ph]);
        write_cfg(REG_PANO_HEIGHT, height_set[ph]);
        cfg_sets++;
      end
      if (ph < 3) begin
        send_idle_pct = 14; recv_idle_pct = 62;
      end else if (ph < 6) begin
        send_idle_pct = 62; recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 6) hold_request = 1;
      for (int n = 0; n < 166; n++) begin
        random_texel(req);
        send_request(req);
      end
    end
    drain();

    $display("Sent %0d texel requests over %0d register settings, checked %0d addresses.",
             reqs_sent, cfg_sets + 1, sb.checked);
    if (sb.mismatches == 0 && sb.pending_addr.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
